/* sv/bvcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvcs_pkg
// Types and constants for the beam vehicle capture sequencer.
// ----------------------------------------------------------------------------
package bvcs_pkg;

	localparam int unsigned BeamW    = 6;
	localparam int unsigned CodeW    = 3;
	localparam int unsigned InDataW  = 8;
	localparam int unsigned OutDataW = 16;

	// capture event codes
	typedef enum logic [CodeW-1:0] {
		EV_CLEAR       = 3'd0,
		EV_FRONT       = 3'd1,
		EV_LONG_REAR   = 3'd2,
		EV_DOUBLE_REAR = 3'd3,
		EV_SHORT_REAR  = 3'd4,
		EV_REVERSE     = 3'd5
	} event_code_t;

	// vehicle tracking flags
	typedef struct packed {
		logic in_channel;
		logic coming;
		logic long_box;
		logic double_box;
		logic high_head;
	} vehicle_flags_t;

endpackage

/* sv/beam_vehicle_capture_sequencer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beam_vehicle_capture_sequencer_unit
// Tracks a vehicle through a channel of infrared beams and raises capture
// events (entry, front, rear, reversing) from polled beam levels.
// ----------------------------------------------------------------------------
//  channel   dir  fields (low bit first)
//  s_*       in   a1,a2,b1,b2,aux_one,aux_two,port_one_ok,port_two_ok
//  m_*       out  beam_state[5:0],state_changed,event_valid,event_code[2:0]
//  cfg_*     in   normally_closed
//
//  One word per cycle sustained while m_tready stays high; a poll passes the
//  input register, then the result register. The vehicle flags and the
//  previous bits are updated as the result register loads, so the next poll
//  sees them. Reset clears all flags and normally_closed.
//  A stall on m_tready holds the result and backs up into s_tready.
// ----------------------------------------------------------------------------
module beam_vehicle_capture_sequencer_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// a1_beam, a2_beam, b1_beam, b2_beam, aux_one, aux_two, port_one_ok, port_two_ok
	input  logic [bvcs_pkg::InDataW-1:0]           s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// beam_state[5:0], state_changed, event_valid, event_code[2:0], zero pad
	output logic [bvcs_pkg::OutDataW-1:0]          m_tdata,
	input  logic                                   cfg_wr_en,
	input  logic                                   cfg_wr_data
);

	logic                                valid_s1;
	logic [bvcs_pkg::InDataW-1:0]        item_s1;
	logic                                out_valid_q;
	logic [bvcs_pkg::OutDataW-1:0]       out_data_q;
	logic                                normally_closed_q;
	logic [bvcs_pkg::BeamW-1:0]          prev_bits_q;
	bvcs_pkg::vehicle_flags_t            flags_q;

	logic                                adv;
	logic                                ok1, ok2;
	logic [bvcs_pkg::BeamW-1:0]          bits;
	logic                                changed;
	logic                                p, q, r, s;
	bvcs_pkg::vehicle_flags_t            flags_d;
	logic                                ev_valid;
	bvcs_pkg::event_code_t               ev_code;

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign ok1 = item_s1[6];
	assign ok2 = item_s1[7];
	// failed port forces its beams and aux bit low
	assign bits = item_s1[5:0] & {ok2, ok1, ok2, ok2, ok1, ok1};
	assign changed = bits != prev_bits_q;

	// blocked level: 1 in normally-open mode, 0 in normally-closed mode
	assign p = bits[0] ^ normally_closed_q;
	assign q = bits[1] ^ normally_closed_q;
	assign r = bits[2] ^ normally_closed_q;
	assign s = bits[3] ^ normally_closed_q;

	always_comb begin
		logic done;
		flags_d  = flags_q;
		ev_valid = 1'b0;
		ev_code  = bvcs_pkg::EV_CLEAR;
		done     = 1'b0;
		if (ok1 && ok2 && changed) begin
			if (flags_d.in_channel && p && !q && !r && !s) begin
				ev_valid           = 1'b1;
				ev_code            = bvcs_pkg::EV_REVERSE;
				flags_d.in_channel = 1'b0;
			end
			if (p && q && !r && !s) begin
				flags_d  = '{in_channel: 1'b0, coming: 1'b1, long_box: 1'b0,
					double_box: 1'b0, high_head: 1'b0};
				ev_valid = 1'b1;
				ev_code  = bvcs_pkg::EV_CLEAR;
			end
			if (flags_d.coming && !flags_d.double_box && p && q && r && s)
				flags_d.long_box = 1'b1;
			if (flags_d.coming && !flags_d.long_box && !flags_d.double_box && p && q && r) begin
				ev_valid = 1'b1;
				ev_code  = bvcs_pkg::EV_FRONT;
			end
			// rear capture ends the chain
			if (flags_d.coming && !p && !q && r && s) begin
				ev_valid = 1'b1;
				priority if (flags_d.double_box) ev_code = bvcs_pkg::EV_DOUBLE_REAR;
				else if (flags_d.long_box)       ev_code = bvcs_pkg::EV_LONG_REAR;
				else                             ev_code = bvcs_pkg::EV_SHORT_REAR;
				flags_d = '{in_channel: 1'b1, coming: 1'b0, long_box: 1'b0,
					double_box: 1'b0, high_head: 1'b0};
				done    = 1'b1;
			end
			if (!done) begin
				if (flags_d.coming && !p && !q && !r && !s) begin
					flags_d.coming    = 1'b0;
					flags_d.high_head = 1'b1;
				end
				if (flags_d.coming && !flags_d.high_head && flags_d.long_box) begin
					if ((p && !q && r && s) || (p && q && !r && s))
						flags_d.double_box = 1'b1;
					if (p && q && r && !s) begin
						flags_d.double_box = 1'b0;
						flags_d.long_box   = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1          <= 1'b0;
			out_valid_q       <= 1'b0;
			normally_closed_q <= 1'b0;
			prev_bits_q       <= '0;
			flags_q           <= '0;
		end else begin
			if (cfg_wr_en)
				normally_closed_q <= cfg_wr_data;
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (adv) begin
				out_valid_q <= 1'b1;
				prev_bits_q <= bits;
				flags_q     <= flags_d;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			item_s1 <= s_tdata;
		if (adv)
			out_data_q <= {5'd0, ev_code, ev_valid, changed, bits};
	end

`ifndef SYNTHESIS
	a_event_needs_change: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && ev_valid) |-> changed)
		else $error("event raised without a change of bits");
	a_idle_code_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[7]) |-> (m_tdata[10:8] == bvcs_pkg::EV_CLEAR))
		else $error("nonzero event code without event");
	a_reverse_needs_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && ev_valid && ev_code == bvcs_pkg::EV_REVERSE) |-> flags_q.in_channel)
		else $error("reversing without a vehicle in channel");
	a_flags_hold_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !(ok1 && ok2)) |=> (flags_q == $past(flags_q)))
		else $error("vehicle flags changed during a port failure");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_tvalid)
		else $error("result lost after advance");
`endif

endmodule
